FILE: hw/rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// shared types and constants of the bounded hash set
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int unsigned Buckets   = 64;
  localparam int unsigned Ways      = 4;
  localparam int unsigned Slots     = Buckets * Ways;
  localparam int unsigned KeyW      = 31;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned EntW      = 9;
  localparam int unsigned BktW      = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SlotW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned RemW      = CfgW + 1;
  localparam int unsigned KeyCntW   = $clog2(KeyW + 1);

  localparam logic [CmdW-1:0] CmdLookup = 2'd0;
  localparam logic [CmdW-1:0] CmdInsert = 2'd1;
  localparam logic [CmdW-1:0] CmdRemove = 2'd2;
  // unused code, behaves as a lookup
  localparam logic [CmdW-1:0] CmdSpare  = 2'd3;

  typedef struct packed {
    logic start;     // load key and begin modulo
    logic mod_step;  // one modulo bit
    logic scan;      // read one way
    logic commit;    // apply update, build result
  } bhs_ctrl_t;

  typedef struct packed {
    logic mod_last;
    logic scan_last;
  } bhs_stat_t;

  typedef struct packed {
    logic            present;
    logic            changed;
    logic            bucket_full;
    logic [EntW-1:0] entries;
  } bhs_res_t;

endpackage

FILE: hw/rtl/bhs_if.sv
// ----------------------------------------------------------------------------
// bhs_req_if / bhs_rsp_if
// valid/ready channels of the bounded hash set
// ----------------------------------------------------------------------------
interface bhs_req_if;
  logic                     valid;
  logic                     ready;
  logic [bhs_pkg::CmdW-1:0] cmd;
  logic [bhs_pkg::KeyW-1:0] key;
  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface bhs_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     present;
  logic                     changed;
  logic                     bucket_full;
  logic [bhs_pkg::EntW-1:0] entries;
  modport source (output valid, present, changed, bucket_full, entries, input ready);
  modport sink   (input valid, present, changed, bucket_full, entries, output ready);
endinterface

FILE: hw/rtl/bhs_ctrl.sv
// ----------------------------------------------------------------------------
// bhs_ctrl
// sequencer: modulo, way scan, commit, then result transfer
// ----------------------------------------------------------------------------
module bhs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bhs_pkg::bhs_stat_t stat_i,
  output bhs_pkg::bhs_ctrl_t ctrl_o
);
  import bhs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // accept a new item when idle and the previous result slot can be freed
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          ctrl_o.start = 1'b1;
          state_d      = StMod;
        end
      end
      StMod: begin
        ctrl_o.mod_step = 1'b1;
        if (stat_i.mod_last) state_d = StScan;
      end
      StScan: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

FILE: hw/rtl/bhs_dpath.sv
// ----------------------------------------------------------------------------
// bhs_dpath
// restoring modulo, slot tables, way compare and entry counter
// ----------------------------------------------------------------------------
module bhs_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bhs_pkg::CfgW-1:0] cfg_data_i,
  input  logic [bhs_pkg::CmdW-1:0] cmd_i,
  input  logic [bhs_pkg::KeyW-1:0] key_i,
  input  bhs_pkg::bhs_ctrl_t       ctrl_i,
  output bhs_pkg::bhs_stat_t       stat_o,
  output bhs_pkg::bhs_res_t        res_o
);
  import bhs_pkg::*;

  logic [CfgW-1:0]    bcount_q;
  logic [RemW-1:0]    modulus;
  logic [KeyW-1:0]    key_q, shift_q;
  logic [CmdW-1:0]    cmd_q;
  logic [RemW-1:0]    rem_q, rem_sh;
  logic [KeyCntW-1:0] bit_q;
  logic [WayW-1:0]    way_q;
  logic               hit_q, free_q;
  logic [WayW-1:0]    hit_way_q, free_way_q;
  logic [EntW-1:0]    total_q;
  logic [Slots-1:0]   used_q;
  logic [KeyW-1:0]    key_mem [Slots];
  logic [KeyW-1:0]    rd_key_q;
  logic               rd_vld_q;
  logic [WayW-1:0]    rd_way_q;
  logic [SlotW-1:0]   rd_addr, base_slot;
  logic [BktW-1:0]    bucket;
  bhs_res_t           res_q;

  // clamp the bucket count to 1..Buckets
  always_comb begin
    if (bcount_q == '0) modulus = RemW'(1);
    else if (RemW'(bcount_q) > RemW'(Buckets)) modulus = RemW'(Buckets);
    else modulus = RemW'(bcount_q);
  end

  assign rem_sh  = {rem_q[RemW-2:0], shift_q[KeyW-1]};
  assign bucket  = BktW'(rem_q);
  assign base_slot = SlotW'({bucket, {WayW{1'b0}}});
  assign rd_addr = SlotW'(base_slot | SlotW'(way_q));

  assign stat_o.mod_last  = (bit_q == KeyCntW'(KeyW - 1));
  assign stat_o.scan_last = rd_vld_q && (rd_way_q == WayW'(Ways - 1));
  assign res_o = res_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcount_q <= CfgW'(64);
    else if (cfg_we_i) bcount_q <= cfg_data_i;
  end

  // modulo one key bit per cycle, then way counter
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      key_q   <= key_i;
      cmd_q   <= cmd_i;
      shift_q <= key_i;
      rem_q   <= '0;
      bit_q   <= '0;
      way_q   <= '0;
    end else if (ctrl_i.mod_step) begin
      shift_q <= {shift_q[KeyW-2:0], 1'b0};
      bit_q   <= bit_q + KeyCntW'(1);
      rem_q   <= (rem_sh >= modulus) ? rem_sh - modulus : rem_sh;
    end else if (ctrl_i.scan && !rd_vld_q) begin
      way_q <= way_q + WayW'(1);
    end else if (ctrl_i.scan && way_q != WayW'(Ways - 1)) begin
      way_q <= way_q + WayW'(1);
    end
  end

  // key memory with registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && cmd_q == CmdInsert && !hit_q && free_q)
      key_mem[SlotW'(base_slot | SlotW'(free_way_q))] <= key_q;
    rd_key_q <= key_mem[rd_addr];
    rd_way_q <= way_q;
  end

  // scan: one way compared per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else if (ctrl_i.start) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else if (ctrl_i.scan) begin
      rd_vld_q <= (way_q != WayW'(Ways - 1)) || !rd_vld_q ? 1'b1 : rd_vld_q;
      if (rd_vld_q) begin
        if (used_q[SlotW'(base_slot | SlotW'(rd_way_q))]) begin
          if (!hit_q && rd_key_q == key_q) begin
            hit_q     <= 1'b1;
            hit_way_q <= rd_way_q;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_way_q <= rd_way_q;
        end
      end
    end
  end

  // commit update and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      total_q <= '0;
    end else if (ctrl_i.commit) begin
      res_q.present     <= hit_q;
      res_q.changed     <= 1'b0;
      res_q.bucket_full <= 1'b0;
      res_q.entries     <= total_q;
      if (cmd_q == CmdInsert && !hit_q) begin
        if (free_q) begin
          used_q[SlotW'(base_slot | SlotW'(free_way_q))] <= 1'b1;
          total_q       <= total_q + EntW'(1);
          res_q.entries <= total_q + EntW'(1);
          res_q.changed <= 1'b1;
        end else begin
          res_q.bucket_full <= 1'b1;
        end
      end else if (cmd_q == CmdRemove && hit_q) begin
        used_q[SlotW'(base_slot | SlotW'(hit_way_q))] <= 1'b0;
        total_q       <= total_q - EntW'(1);
        res_q.entries <= total_q - EntW'(1);
        res_q.changed <= 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/bounded_hash_set_top.sv
// ----------------------------------------------------------------------------
// bounded_hash_set_top
// bucketed set of 31-bit keys with lookup, insert and remove
// ----------------------------------------------------------------------------
// Each item passes through the bit-serial key modulo the bucket count, a
// scan of the ways behind the registered key memory read, a commit step,
// then the result transfer; one item is in work at a time.
// The slot valid bits clear at reset, so no clearing pass is needed.
module bounded_hash_set_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bhs_pkg::CfgW-1:0] cfg_data_i,
  bhs_req_if.sink                  req,
  bhs_rsp_if.source                rsp
);
  import bhs_pkg::*;

  bhs_ctrl_t ctrl;
  bhs_stat_t stat;
  bhs_res_t  res;

  // sequencer
  bhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // datapath
  bhs_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (req.cmd),
    .key_i      (req.key),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_o      (res)
  );

  assign rsp.present     = res.present;
  assign rsp.changed     = res.changed;
  assign rsp.bucket_full = res.bucket_full;
  assign rsp.entries     = res.entries;
endmodule

FILE: sim/bounded_hash_set_checker.sv
// ----------------------------------------------------------------------------
// bounded_hash_set_checker
// watches the request and result channels, predicts each result of the
// bounded hash set and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module bounded_hash_set_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bhs_pkg::CfgW-1:0] cfg_data_i,
  bhs_req_if.sink                  req,
  bhs_rsp_if.sink                  rsp,
  output int unsigned              fail_cnt_o,
  output int unsigned              pending_o
);
  import bhs_pkg::*;

  // predicted table contents
  logic                slot_busy_q [Slots];
  logic [KeyW-1:0]     slot_tag_q  [Slots];
  logic [EntW-1:0]     key_total_q;
  logic [CfgW-1:0]     modulus_q;
  bhs_res_t            result_fifo [$];

  assign pending_o = result_fifo.size();

  // apply one operation to the predicted table and return its result
  function automatic bhs_res_t apply_set_op(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key);
    int unsigned n;
    int unsigned base;
    int          hit;
    int          free_idx;
    bhs_res_t    r;
    n = modulus_q;
    if (n == 0) n = 1;
    if (n > Buckets) n = Buckets;
    base = (key % n) * Ways;
    hit = -1;
    free_idx = -1;
    r = '0;
    for (int w = 0; w < Ways; w++) begin
      if (slot_busy_q[base + w]) begin
        if (hit < 0 && slot_tag_q[base + w] == key) hit = base + w;
      end else if (free_idx < 0) begin
        free_idx = base + w;
      end
    end
    r.present = (hit >= 0);
    if (cmd == CmdInsert) begin
      if (hit < 0) begin
        if (free_idx >= 0) begin
          slot_busy_q[free_idx] = 1'b1;
          slot_tag_q[free_idx]  = key;
          key_total_q           = key_total_q + 1'b1;
          r.changed             = 1'b1;
        end else begin
          r.bucket_full = 1'b1;
        end
      end
    end else if (cmd == CmdRemove) begin
      if (hit >= 0) begin
        slot_busy_q[hit] = 1'b0;
        key_total_q      = key_total_q - 1'b1;
        r.changed        = 1'b1;
      end
    end
    r.entries = key_total_q;
    return r;
  endfunction

  // predict on each request transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    bhs_res_t want;
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        slot_busy_q[s] = 1'b0;
        slot_tag_q[s]  = '0;
      end
      key_total_q = '0;
      modulus_q   = 7'd64;
      fail_cnt_o  = 0;
      result_fifo.delete();
    end else begin
      if (cfg_we_i) modulus_q = cfg_data_i;
      if (req.valid && req.ready) result_fifo.push_back(apply_set_op(req.cmd, req.key));
      if (rsp.valid && rsp.ready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result present=%0b changed=%0b full=%0b entries=%0d",
                   $time, rsp.present, rsp.changed, rsp.bucket_full, rsp.entries);
          fail_cnt_o++;
        end else begin
          want = result_fifo.pop_front();
          if (rsp.present !== want.present || rsp.changed !== want.changed ||
              rsp.bucket_full !== want.bucket_full || rsp.entries !== want.entries) begin
            $display("%0t: mismatch expected p=%0b c=%0b f=%0b n=%0d actual p=%0b c=%0b f=%0b n=%0d",
                     $time, want.present, want.changed, want.bucket_full, want.entries,
                     rsp.present, rsp.changed, rsp.bucket_full, rsp.entries);
            fail_cnt_o++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/bounded_hash_set_top_test.sv
// ----------------------------------------------------------------------------
// bounded_hash_set_top_test
// drives lookups, inserts and removes under several bucket counts with random
// gaps and stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
module bounded_hash_set_top_test;
  import bhs_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  int unsigned     fail_cnt;
  int unsigned     pending;
  int unsigned     cycle_cnt = 0;
  logic            hold_rsp = 1'b0;
  logic [KeyW-1:0] key_pool [16];

  bhs_req_if req ();
  bhs_rsp_if rsp ();

  bounded_hash_set_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .req(req.sink), .rsp(rsp.source)
  );

  bounded_hash_set_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .req(req.sink), .rsp(rsp.sink),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.cmd   = CmdLookup;
    req.key   = '0;
    rsp.ready = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("bounded_hash_set_top verification failed");
      $finish;
    end
  end

  // result side: random stalls, and one long hold-off when asked
  initial begin
    int unsigned gap;
    logic        long_hold;
    logic        held;
    held = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      long_hold = hold_rsp && !held;
      if (long_hold) held = 1'b1;
      if (gap != 0 || long_hold) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (long_hold) repeat (400) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
    end
  end

  // one request transfer after a random gap; valid stays up for a next item
  task automatic send_op(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.cmd   <= cmd;
    req.key   <= key;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  // wait for every result, then let the block settle before a register write
  task automatic drain_and_set(logic [CfgW-1:0] value);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly keys from a small pool that shares few buckets, to fill buckets
  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return KeyW'($urandom() & 32'h7fff_ffff);
    return key_pool[$urandom_range(0, 15)];
  endfunction

  initial begin
    logic [CfgW-1:0] mod_list [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd64};
    logic [CmdW-1:0] op;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key extremes, every command, full bucket, duplicates
    send_op(CmdLookup, '0);
    send_op(CmdInsert, '0);
    send_op(CmdInsert, '0);
    send_op(CmdInsert, 31'h7fff_ffff);
    send_op(CmdInsert, 31'd64);
    send_op(CmdInsert, 31'd128);
    send_op(CmdInsert, 31'd192);
    send_op(CmdInsert, 31'd256);
    send_op(CmdLookup, 31'd192);
    send_op(CmdSpare, 31'd64);
    send_op(CmdRemove, 31'd64);
    send_op(CmdRemove, 31'd64);
    send_op(CmdInsert, 31'd256);
    send_op(CmdLookup, 31'h7fff_ffff);
    send_op(CmdRemove, 31'h7fff_ffff);
    // stale keys under a new modulus, then a duplicate copy
    drain_and_set(7'd3);
    send_op(CmdLookup, 31'd128);
    send_op(CmdInsert, 31'd128);
    send_op(CmdLookup, 31'h5555_5555);

    // random phases across bucket counts, each starting from the current set
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set(mod_list[ph]);
      for (int k = 0; k < 16; k++)
        key_pool[k] = KeyW'((($urandom_range(0, 3) * 64) + $urandom_range(0, 2) +
                             $urandom_range(0, 31) * 448) & 31'h7fff_ffff);
      key_pool[0] = 31'h7fff_ffff;
      if (ph == 2) hold_rsp <= 1'b1;
      for (int i = 0; i < 170; i++) begin
        op = ($urandom_range(0, 9) < 5) ? CmdInsert : CmdW'($urandom_range(0, 3));
        send_op(op, pick_key());
      end
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("bounded_hash_set_top verification clean");
    end else begin
      $display("bounded_hash_set_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bhs_pkg.sv
hw/rtl/bhs_if.sv
hw/rtl/bhs_ctrl.sv
hw/rtl/bhs_dpath.sv
hw/rtl/bounded_hash_set_top.sv
sim/bounded_hash_set_checker.sv
sim/bounded_hash_set_top_test.sv
